### design/rgc_pkg.sv
package rgc_pkg;

  localparam int FRAC_BITS = 10;

  localparam int POS_W      = 15;
  localparam int DIR_W      = 12;
  localparam int SIZE_W     = 11;
  localparam int IDX_W      = 10;
  localparam int TILE_W     = 4;
  localparam int COL_W      = 10;
  localparam int SPAN_W     = 10;
  localparam int COLOR_W    = 8;
  localparam int DIST_W     = 31;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  // Shared divider: 21-bit dividend, 42-bit divisor, 21-bit quotient.
  localparam int DIV_NUM_W = 21;
  localparam int DIV_DEN_W = 42;

  localparam int DELTA_W = 31;
  localparam int SD_W    = 42;

  localparam int QUEUE_DEPTH = 2;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_POS_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_X    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_X  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_Y  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SCR_W    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SCR_H    = 3'd7;

  localparam logic [DELTA_W-1:0] NO_STEP_DELTA = 31'd2147483640;
  localparam logic [DIST_W-1:0]  DIST_MAX      = 31'd2147483647;
  localparam logic [COLOR_W-1:0] COLOR_FULL    = 8'd255;

  typedef struct packed {
    logic [POS_W-1:0]        pos_x;
    logic [POS_W-1:0]        pos_y;
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
    logic signed [DIR_W-1:0] plane_x;
    logic signed [DIR_W-1:0] plane_y;
    logic [SIZE_W-1:0]       scr_w;
    logic [SIZE_W-1:0]       scr_h;
  } cfg_t;

  typedef struct packed {
    logic              opcode;
    logic [IDX_W-1:0]  cell_index;
    logic [TILE_W-1:0] cell_value;
    logic [COL_W-1:0]  column;
  } q_item_t;

  typedef struct packed {
    logic [COL_W-1:0]   out_column;
    logic [SPAN_W-1:0]  span_start;
    logic [SPAN_W-1:0]  span_end;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               hit_side;
    logic [TILE_W-1:0]  hit_tile;
    logic [DIST_W-1:0]  wall_distance;
  } result_t;

endpackage

### design/rgc_div.sv
module rgc_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            go,
  input  logic [rgc_pkg::DIV_NUM_W-1:0]   num,
  input  logic [rgc_pkg::DIV_DEN_W-1:0]   den,
  output logic                            done,
  output logic [rgc_pkg::DIV_NUM_W-1:0]   quot
);
  import rgc_pkg::*;

  localparam int CNT_W = $clog2(DIV_NUM_W + 1);

  logic                 running;
  logic [CNT_W-1:0]     cnt;
  logic [DIV_DEN_W:0]   rem;
  logic [DIV_NUM_W-1:0] num_sh;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_DEN_W:0]   trial;
  logic                 fits;

  // One quotient bit per cycle, restoring form.
  assign trial = {rem[DIV_DEN_W-1:0], num_sh[DIV_NUM_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
        cnt     <= '0;
        rem     <= '0;
        num_sh  <= num;
        den_r   <= den;
      end else if (running) begin
        rem    <= fits ? trial - {1'b0, den_r} : trial;
        num_sh <= {num_sh[DIV_NUM_W-2:0], 1'b0};
        quot   <= {quot[DIV_NUM_W-2:0], fits};
        if (cnt == CNT_W'(DIV_NUM_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

endmodule

### design/rgc_queue.sv
module rgc_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rgc_pkg::q_item_t  push_item,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output rgc_pkg::q_item_t  head_item
);
  import rgc_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  q_item_t            slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W:0]     count;

  assign full       = count == (PTR_W + 1)'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && head_valid) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (PTR_W + 1)'(push && !full) - (PTR_W + 1)'(pop && head_valid);
    end
  end

endmodule

### design/rgc_front.sv
module rgc_front #(
  parameter int CELL_COUNT = 1024
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic                             opcode,
  input  logic [rgc_pkg::IDX_W-1:0]        cell_index,
  input  logic [rgc_pkg::TILE_W-1:0]       cell_value,
  input  logic [rgc_pkg::COL_W-1:0]        column,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rgc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rgc_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             clearing,
  input  logic                             q_full,
  output logic                             push,
  output rgc_pkg::q_item_t                 push_item,
  output rgc_pkg::cfg_t                    cfg
);
  import rgc_pkg::*;

  logic [POS_W-1:0]        pos_x, pos_y;
  logic signed [DIR_W-1:0] dir_x, dir_y, plane_x, plane_y;
  logic [SIZE_W-1:0]       scr_w, scr_h;
  logic                    f_valid;
  q_item_t                 f_item;
  logic                    accept;
  logic                    keep;

  assign cfg_ready = 1'b1;
  assign busy      = clearing || (f_valid && q_full);
  assign accept    = start && !busy;
  // A tile write outside the map is dropped here and never reaches the queue.
  assign keep      = (opcode == OP_CAST) || (32'(cell_index) < CELL_COUNT);
  assign push      = f_valid && !q_full;
  assign push_item = f_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= keep;
    end else if (push) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_item <= '{opcode: opcode, cell_index: cell_index, cell_value: cell_value,
                  column: column};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x   <= 15'd22528;
      pos_y   <= 15'd12288;
      dir_x   <= -12'sd1024;
      dir_y   <= 12'sd0;
      plane_x <= 12'sd0;
      plane_y <= 12'sd676;
      scr_w   <= 11'd320;
      scr_h   <= 11'd240;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_POS_X:   pos_x   <= cfg_data[POS_W-1:0];
        CFG_POS_Y:   pos_y   <= cfg_data[POS_W-1:0];
        CFG_DIR_X:   dir_x   <= $signed(cfg_data[DIR_W-1:0]);
        CFG_DIR_Y:   dir_y   <= $signed(cfg_data[DIR_W-1:0]);
        CFG_PLANE_X: plane_x <= $signed(cfg_data[DIR_W-1:0]);
        CFG_PLANE_Y: plane_y <= $signed(cfg_data[DIR_W-1:0]);
        CFG_SCR_W:   scr_w   <= cfg_data[SIZE_W-1:0];
        CFG_SCR_H:   scr_h   <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] r;
    if (s == '0) begin
      r = 11'd1;
    end else if (s > 11'd1024) begin
      r = 11'd1024;
    end else begin
      r = s;
    end
    return r;
  endfunction

  always_comb begin
    cfg.pos_x   = pos_x;
    cfg.pos_y   = pos_y;
    cfg.dir_x   = dir_x;
    cfg.dir_y   = dir_y;
    cfg.plane_x = plane_x;
    cfg.plane_y = plane_y;
    cfg.scr_w   = clamp_size(scr_w);
    cfg.scr_h   = clamp_size(scr_h);
  end

endmodule

### design/rgc_back.sv
module rgc_back #(
  parameter int MAP_WIDTH  = 32,
  parameter int MAP_HEIGHT = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  rgc_pkg::cfg_t      cfg,
  input  logic               head_valid,
  input  rgc_pkg::q_item_t   head_item,
  output logic               pop,
  output logic               clearing,
  output logic               done,
  output rgc_pkg::result_t   result
);
  import rgc_pkg::*;

  localparam int CELL_COUNT = MAP_WIDTH * MAP_HEIGHT;
  localparam int CELL_AW    = $clog2(CELL_COUNT);

  localparam logic [4:0] S_CLEAR = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_CAMW  = 5'd2;
  localparam logic [4:0] S_RAY   = 5'd3;
  localparam logic [4:0] S_RAY2  = 5'd4;
  localparam logic [4:0] S_DDX   = 5'd5;
  localparam logic [4:0] S_DDXW  = 5'd6;
  localparam logic [4:0] S_DDY   = 5'd7;
  localparam logic [4:0] S_DDYW  = 5'd8;
  localparam logic [4:0] S_SD    = 5'd9;
  localparam logic [4:0] S_STEP  = 5'd10;
  localparam logic [4:0] S_BOUND = 5'd11;
  localparam logic [4:0] S_READ  = 5'd12;
  localparam logic [4:0] S_PERP  = 5'd13;
  localparam logic [4:0] S_LH    = 5'd14;
  localparam logic [4:0] S_LHW   = 5'd15;
  localparam logic [4:0] S_OUT   = 5'd16;

  logic [4:0] state;

  logic [TILE_W-1:0]  mem [CELL_COUNT];
  logic               mem_we;
  logic [CELL_AW-1:0] mem_wa;
  logic [TILE_W-1:0]  mem_wd;
  logic               mem_re;
  logic [CELL_AW-1:0] mem_ra;
  logic [TILE_W-1:0]  mem_q;
  logic [CELL_AW-1:0] clr_cnt;

  logic                  div_go;
  logic [DIV_NUM_W-1:0]  div_num;
  logic [DIV_DEN_W-1:0]  div_den;
  logic                  div_done;
  logic [DIV_NUM_W-1:0]  div_q;

  logic [COL_W-1:0]      col_r;
  logic signed [22:0]    cam;
  logic signed [34:0]    prod_x, prod_y;
  logic signed [25:0]    rdx, rdy;
  logic [25:0]           rdx_abs, rdy_abs;
  logic [DELTA_W-1:0]    ddx, ddy;
  logic [SD_W-1:0]       sdx, sdy;
  logic signed [9:0]     cx, cy;
  logic                  side;
  logic [TILE_W-1:0]     tile;
  logic signed [SD_W:0]  perp;
  logic [DIV_NUM_W-1:0]  lh;

  logic [SIZE_W-1:0]     frac_x, frac_y;
  logic [SD_W-1:0]       mul_x, mul_y;
  logic                  oob;

  logic signed [21:0]    st_s;
  logic [20:0]           en_u;
  logic [COLOR_W-1:0]    r_c, g_c, b_c;
  logic [DIST_W-1:0]     dist_c;
  logic [SPAN_W-1:0]     span_s_c, span_e_c;

  rgc_div u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (div_go),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quot (div_q)
  );

  assign clearing = state == S_CLEAR;
  assign pop      = state == S_IDLE && head_valid;

  assign rdx_abs = rdx[25] ? 26'(-rdx) : 26'(rdx);
  assign rdy_abs = rdy[25] ? 26'(-rdy) : 26'(rdy);

  // Distance to the first grid line on each axis, in cell fractions.
  assign frac_x = rdx[25] ? {1'b0, cfg.pos_x[FRAC_BITS-1:0]}
                          : 11'd1024 - {1'b0, cfg.pos_x[FRAC_BITS-1:0]};
  assign frac_y = rdy[25] ? {1'b0, cfg.pos_y[FRAC_BITS-1:0]}
                          : 11'd1024 - {1'b0, cfg.pos_y[FRAC_BITS-1:0]};
  assign mul_x  = SD_W'(frac_x) * SD_W'(ddx);
  assign mul_y  = SD_W'(frac_y) * SD_W'(ddy);

  assign oob = cx < 10'sd0 || cx >= $signed(10'(MAP_WIDTH))
            || cy < 10'sd0 || cy >= $signed(10'(MAP_HEIGHT));

  always_comb begin
    div_go  = 1'b0;
    div_num = '0;
    div_den = '0;
    unique case (state)
      S_IDLE: begin
        div_go  = head_valid && head_item.opcode == OP_CAST;
        div_num = {head_item.column, 11'b0};
        div_den = DIV_DEN_W'(cfg.scr_w);
      end
      S_DDX: begin
        div_go  = rdx != '0;
        div_num = DIV_NUM_W'(1) << (2 * FRAC_BITS);
        div_den = DIV_DEN_W'(rdx_abs);
      end
      S_DDY: begin
        div_go  = rdy != '0;
        div_num = DIV_NUM_W'(1) << (2 * FRAC_BITS);
        div_den = DIV_DEN_W'(rdy_abs);
      end
      S_LH: begin
        div_go  = perp > 0;
        div_num = {cfg.scr_h, 10'b0};
        div_den = perp[DIV_DEN_W-1:0];
      end
      default: ;
    endcase
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = clr_cnt;
    mem_wd = '0;
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (pop && head_item.opcode == OP_WRITE) begin
      mem_we = 1'b1;
      mem_wa = CELL_AW'(head_item.cell_index);
      mem_wd = head_item.cell_value;
    end
    mem_re = state == S_BOUND && !oob;
    mem_ra = CELL_AW'(32'(cy[8:0]) * MAP_WIDTH + 32'(cx[8:0]));
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_q <= mem[mem_ra];
    end
  end

  // Wall span, colour and saturated distance for the result word.
  always_comb begin
    st_s = $signed({12'b0, cfg.scr_h[SIZE_W-1:1]}) - $signed({2'b0, lh[20:1]});
    en_u = {11'b0, cfg.scr_h[SIZE_W-1:1]} + {1'b0, lh[20:1]};
    span_s_c = st_s < 0 ? '0 : st_s[SPAN_W-1:0];
    span_e_c = (en_u >= {10'b0, cfg.scr_h}) ? SPAN_W'(cfg.scr_h - 1'b1)
                                             : en_u[SPAN_W-1:0];
    r_c = '0;
    g_c = '0;
    b_c = '0;
    case (tile)
      4'd1: r_c = COLOR_FULL;
      4'd2: g_c = COLOR_FULL;
      4'd3: b_c = COLOR_FULL;
      4'd4: begin
        r_c = COLOR_FULL;
        g_c = COLOR_FULL;
        b_c = COLOR_FULL;
      end
      default: begin
        r_c = COLOR_FULL;
        g_c = COLOR_FULL;
      end
    endcase
    if (side) begin
      r_c = r_c >> 1;
      g_c = g_c >> 1;
      b_c = b_c >> 1;
    end
    if (perp < 0) begin
      dist_c = '0;
    end else if (|perp[SD_W:DIST_W]) begin
      dist_c = DIST_MAX;
    end else begin
      dist_c = perp[DIST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == CELL_AW'(CELL_COUNT - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (head_valid && head_item.opcode == OP_CAST) begin
            col_r <= head_item.column;
            state <= S_CAMW;
          end
        end
        S_CAMW: begin
          if (div_done) begin
            cam   <= $signed({2'b0, div_q}) - 23'sd1024;
            state <= S_RAY;
          end
        end
        S_RAY: begin
          prod_x <= cfg.plane_x * cam;
          prod_y <= cfg.plane_y * cam;
          state  <= S_RAY2;
        end
        S_RAY2: begin
          rdx   <= 26'(cfg.dir_x) + 26'(prod_x >>> FRAC_BITS);
          rdy   <= 26'(cfg.dir_y) + 26'(prod_y >>> FRAC_BITS);
          state <= S_DDX;
        end
        S_DDX: begin
          if (rdx == '0) begin
            ddx   <= NO_STEP_DELTA;
            state <= S_DDY;
          end else begin
            state <= S_DDXW;
          end
        end
        S_DDXW: begin
          if (div_done) begin
            ddx   <= DELTA_W'(div_q);
            state <= S_DDY;
          end
        end
        S_DDY: begin
          if (rdy == '0) begin
            ddy   <= NO_STEP_DELTA;
            state <= S_SD;
          end else begin
            state <= S_DDYW;
          end
        end
        S_DDYW: begin
          if (div_done) begin
            ddy   <= DELTA_W'(div_q);
            state <= S_SD;
          end
        end
        S_SD: begin
          sdx   <= mul_x >> FRAC_BITS;
          sdy   <= mul_y >> FRAC_BITS;
          cx    <= $signed({5'b0, cfg.pos_x[POS_W-1:FRAC_BITS]});
          cy    <= $signed({5'b0, cfg.pos_y[POS_W-1:FRAC_BITS]});
          state <= S_STEP;
        end
        S_STEP: begin
          if (sdx < sdy) begin
            sdx  <= sdx + SD_W'(ddx);
            cx   <= rdx[25] ? cx - 10'sd1 : cx + 10'sd1;
            side <= 1'b0;
          end else begin
            sdy  <= sdy + SD_W'(ddy);
            cy   <= rdy[25] ? cy - 10'sd1 : cy + 10'sd1;
            side <= 1'b1;
          end
          state <= S_BOUND;
        end
        S_BOUND: begin
          if (oob) begin
            // Leaving the map reads as an x-side hit on an empty tile.
            side  <= 1'b0;
            tile  <= '0;
            state <= S_PERP;
          end else begin
            state <= S_READ;
          end
        end
        S_READ: begin
          if (mem_q != '0) begin
            tile  <= mem_q;
            state <= S_PERP;
          end else begin
            state <= S_STEP;
          end
        end
        S_PERP: begin
          perp  <= side ? $signed({1'b0, sdy}) - $signed({12'b0, ddy})
                        : $signed({1'b0, sdx}) - $signed({12'b0, ddx});
          state <= S_LH;
        end
        S_LH: begin
          if (perp > 0) begin
            state <= S_LHW;
          end else begin
            lh    <= DIV_NUM_W'(cfg.scr_h);
            state <= S_OUT;
          end
        end
        S_LHW: begin
          if (div_done) begin
            lh    <= div_q;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          result.out_column    <= col_r;
          result.span_start    <= span_s_c;
          result.span_end      <= span_e_c;
          result.red           <= r_c;
          result.green         <= g_c;
          result.blue          <= b_c;
          result.hit_side      <= side;
          result.hit_tile      <= tile;
          result.wall_distance <= dist_c;
          done                 <= 1'b1;
          state                <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### design/grid_ray_cast_column_top.sv
// Tile write: registered in the front stage, then queued; the back end writes it into the
// map as it pops it while idle. No result; one write per cycle while the back end is idle.
// Cast: four divider waits and a walk of S_STEP, S_BOUND and S_READ per grid cell (S_READ
// skipped on the cell where the ray leaves the map); a zero ray component or a distance not
// above zero skips that divider wait. Queued casts run one at a time; three more words fit
// while one is at work. After rst busy stays high while the map clears.
module grid_ray_cast_column_top #(
  parameter int MAP_WIDTH  = 32,
  parameter int MAP_HEIGHT = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic                             opcode,
  input  logic [rgc_pkg::IDX_W-1:0]        cell_index,
  input  logic [rgc_pkg::TILE_W-1:0]       cell_value,
  input  logic [rgc_pkg::COL_W-1:0]        column,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rgc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rgc_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                             done,
  output logic [rgc_pkg::COL_W-1:0]        out_column,
  output logic [rgc_pkg::SPAN_W-1:0]       span_start,
  output logic [rgc_pkg::SPAN_W-1:0]       span_end,
  output logic [rgc_pkg::COLOR_W-1:0]      red,
  output logic [rgc_pkg::COLOR_W-1:0]      green,
  output logic [rgc_pkg::COLOR_W-1:0]      blue,
  output logic                             hit_side,
  output logic [rgc_pkg::TILE_W-1:0]       hit_tile,
  output logic [rgc_pkg::DIST_W-1:0]       wall_distance
);
  import rgc_pkg::*;

  cfg_t    cfg;
  q_item_t push_item;
  q_item_t head_item;
  result_t result;
  logic    push, q_full, pop, head_valid, clearing;

  rgc_front #(
    .CELL_COUNT (MAP_WIDTH * MAP_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .opcode     (opcode),
    .cell_index (cell_index),
    .cell_value (cell_value),
    .column     (column),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .clearing   (clearing),
    .q_full     (q_full),
    .push       (push),
    .push_item  (push_item),
    .cfg        (cfg)
  );

  rgc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  rgc_back #(
    .MAP_WIDTH  (MAP_WIDTH),
    .MAP_HEIGHT (MAP_HEIGHT)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .clearing   (clearing),
    .done       (done),
    .result     (result)
  );

  assign out_column    = result.out_column;
  assign span_start    = result.span_start;
  assign span_end      = result.span_end;
  assign red           = result.red;
  assign green         = result.green;
  assign blue          = result.blue;
  assign hit_side      = result.hit_side;
  assign hit_tile      = result.hit_tile;
  assign wall_distance = result.wall_distance;

endmodule

### verif/tb_grid_ray_cast_column_top.sv
`timescale 1ns / 1ps

module tb_grid_ray_cast_column_top;
  import rgc_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic opcode = OP_WRITE;
  logic [IDX_W-1:0] cell_index = '0;
  logic [TILE_W-1:0] cell_value = '0;
  logic [COL_W-1:0] column = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic done;
  logic [COL_W-1:0] out_column;
  logic [SPAN_W-1:0] span_start, span_end;
  logic [COLOR_W-1:0] red, green, blue;
  logic hit_side;
  logic [TILE_W-1:0] hit_tile;
  logic [DIST_W-1:0] wall_distance;

  grid_ray_cast_column_top uut (.*);

  always #10 clk = ~clk;

  localparam int CELLS = 32 * 32;

  q_item_t pending_q[$];
  result_t column_q[$];
  logic [TILE_W-1:0] tile_mirror[CELLS];
  cfg_t cam;
  int idle_pct = 0;
  int errors = 0;
  int casts_seen = 0;
  int writes_sent = 0;
  bit taken = 1'b0;

  function automatic longint ray_delta(longint d);
    longint q;
    if (d == 0) return 64'sd2147483640;
    q = 64'sd1048576 / d;
    return (q < 0) ? -q : q;
  endfunction

  function automatic result_t cast_column(logic [COL_W-1:0] col);
    longint w, h, cm, rdx, rdy, ddx, ddy, sdx, sdy, px, py, perp, lh, st, en;
    longint cx, cy, sx, sy;
    int side, tile;
    result_t r;
    w = (cam.scr_w == 0) ? 1 : (cam.scr_w > 1024) ? 1024 : cam.scr_w;
    h = (cam.scr_h == 0) ? 1 : (cam.scr_h > 1024) ? 1024 : cam.scr_h;
    px = cam.pos_x;
    py = cam.pos_y;
    cm = (2 * longint'(col) * 1024) / w - 1024;
    rdx = longint'($signed(cam.dir_x)) + ((longint'($signed(cam.plane_x)) * cm) >>> 10);
    rdy = longint'($signed(cam.dir_y)) + ((longint'($signed(cam.plane_y)) * cm) >>> 10);
    cx = px >> 10;
    cy = py >> 10;
    ddx = ray_delta(rdx);
    ddy = ray_delta(rdy);
    if (rdx < 0) begin
      sx = -1; sdx = ((px - cx * 1024) * ddx) >> 10;
    end else begin
      sx = 1; sdx = (((cx + 1) * 1024 - px) * ddx) >> 10;
    end
    if (rdy < 0) begin
      sy = -1; sdy = ((py - cy * 1024) * ddy) >> 10;
    end else begin
      sy = 1; sdy = (((cy + 1) * 1024 - py) * ddy) >> 10;
    end
    side = 0;
    tile = 0;
    forever begin
      if (sdx < sdy) begin
        sdx += ddx; cx += sx; side = 0;
      end else begin
        sdy += ddy; cy += sy; side = 1;
      end
      if (cx < 0 || cx >= 32 || cy < 0 || cy >= 32) begin
        side = 0;
        tile = 0;
        break;
      end
      tile = tile_mirror[cy * 32 + cx];
      if (tile != 0) break;
    end
    perp = (side == 0) ? sdx - ddx : sdy - ddy;
    lh = (perp > 0) ? (h * 1024) / perp : h;
    st = h / 2 - lh / 2;
    en = h / 2 + lh / 2;
    if (st < 0) st = 0;
    if (en >= h) en = h - 1;
    r = '0;
    case (tile)
      1: r.red = COLOR_FULL;
      2: r.green = COLOR_FULL;
      3: r.blue = COLOR_FULL;
      4: begin
        r.red = COLOR_FULL; r.green = COLOR_FULL; r.blue = COLOR_FULL;
      end
      default: begin
        r.red = COLOR_FULL; r.green = COLOR_FULL;
      end
    endcase
    if (side == 1) begin
      r.red = r.red >> 1; r.green = r.green >> 1; r.blue = r.blue >> 1;
    end
    r.out_column = col;
    r.span_start = st[SPAN_W-1:0];
    r.span_end = en[SPAN_W-1:0];
    r.hit_side = side[0];
    r.hit_tile = tile[TILE_W-1:0];
    r.wall_distance = (perp < 0) ? '0 : (perp > 64'sd2147483647) ? DIST_MAX
                                        : perp[DIST_W-1:0];
    return r;
  endfunction

  function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    case (idx)
      CFG_POS_X:   cam.pos_x = v;
      CFG_POS_Y:   cam.pos_y = v;
      CFG_DIR_X:   cam.dir_x = v[DIR_W-1:0];
      CFG_DIR_Y:   cam.dir_y = v[DIR_W-1:0];
      CFG_PLANE_X: cam.plane_x = v[DIR_W-1:0];
      CFG_PLANE_Y: cam.plane_y = v[DIR_W-1:0];
      CFG_SCR_W:   cam.scr_w = v[SIZE_W-1:0];
      CFG_SCR_H:   cam.scr_h = v[SIZE_W-1:0];
      default: ;
    endcase
  endfunction

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t mismatch %s: expected %0d, actual %0d", $realtime, name, want, got);
      errors++;
    end
  endtask

  // Driver: present the head of the queue, hold it until the block takes it.
  always @(negedge clk) begin
    if (!rst && !(start && !taken) && pending_q.size() > 0 &&
        $urandom_range(99) >= idle_pct) begin
      start <= 1'b1;
      opcode <= pending_q[0].opcode;
      cell_index <= pending_q[0].cell_index;
      cell_value <= pending_q[0].cell_value;
      column <= pending_q[0].column;
      taken = 1'b0;
    end else if (!(start && !taken)) begin
      start <= 1'b0;
    end
  end

  // Acceptance and result monitor.
  always @(posedge clk) begin
    result_t got, want;
    if (!rst && start && !busy && !taken) begin
      taken = 1'b1;
      if (pending_q[0].opcode == OP_CAST)
        column_q.push_back(cast_column(pending_q[0].column));
      else
        tile_mirror[pending_q[0].cell_index] = pending_q[0].cell_value;
      void'(pending_q.pop_front());
    end
    if (!rst && done) begin
      got = '{out_column, span_start, span_end, red, green, blue, hit_side, hit_tile,
              wall_distance};
      casts_seen++;
      if (column_q.size() == 0) begin
        $display("%0t mismatch: result with none expected, actual column %0d",
                 $realtime, out_column);
        errors++;
      end else begin
        want = column_q.pop_front();
        check_field("out_column", want.out_column, got.out_column);
        check_field("span_start", want.span_start, got.span_start);
        check_field("span_end", want.span_end, got.span_end);
        check_field("red", want.red, got.red);
        check_field("green", want.green, got.green);
        check_field("blue", want.blue, got.blue);
        check_field("hit_side", want.hit_side, got.hit_side);
        check_field("hit_tile", want.hit_tile, got.hit_tile);
        check_field("wall_distance", want.wall_distance, got.wall_distance);
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    apply_cfg(idx, v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Tile writes give no result, so allow the block to finish them after the last cast.
  task automatic drain();
    while (pending_q.size() > 0 || column_q.size() > 0 || (start && !taken))
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic add_item(bit op, int idx, int val, int col);
    q_item_t it;
    it.opcode = op;
    it.cell_index = IDX_W'(idx);
    it.cell_value = TILE_W'(val);
    it.column = COL_W'(col);
    if (op == OP_WRITE) writes_sent++;
    pending_q.push_back(it);
  endtask

  task automatic random_items(int n);
    int w;
    w = (cam.scr_w == 0) ? 1 : (cam.scr_w > 1024) ? 1024 : cam.scr_w;
    repeat (n) begin
      if ($urandom_range(99) < 35)
        add_item(OP_WRITE, $urandom_range(1023),
                 ($urandom_range(1) ? $urandom_range(15) : 0), $urandom_range(1023));
      else
        add_item(OP_CAST, $urandom_range(1023), $urandom_range(15),
                 ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(w - 1));
    end
  endtask

  initial begin
    cam = '{15'd22528, 15'd12288, -12'sd1024, 12'sd0, 12'sd0, 12'sd676, 11'd320, 11'd240};
    foreach (tile_mirror[i]) tile_mirror[i] = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Empty map first: every ray runs to the edge. The middle column has no y component.
    add_item(OP_CAST, 0, 0, 0);
    add_item(OP_CAST, 0, 0, 160);
    add_item(OP_CAST, 0, 0, 319);
    add_item(OP_CAST, 1023, 15, 1023);
    // Tile right in front of the viewer on a cell boundary gives a zero distance.
    add_item(OP_WRITE, 12 * 32 + 21, 1, 0);
    add_item(OP_CAST, 0, 0, 160);
    for (int v = 2; v < 16; v++) add_item(OP_WRITE, 12 * 32 + 21 - v / 4 + (v % 4) * 32, v, 0);
    add_item(OP_WRITE, 0, 4, 0);
    add_item(OP_WRITE, 1023, 15, 1023);
    add_item(OP_CAST, 0, 0, 100);
    add_item(OP_CAST, 0, 0, 250);
    drain();

    // Extremes of the camera and screen registers.
    write_reg(CFG_POS_X, 15'h7fff);
    write_reg(CFG_POS_Y, 15'h0000);
    write_reg(CFG_DIR_X, 15'h07ff);
    write_reg(CFG_DIR_Y, 15'h7800);
    write_reg(CFG_PLANE_X, 15'h0800);
    write_reg(CFG_PLANE_Y, 15'h07ff);
    write_reg(CFG_SCR_W, 15'd0);
    write_reg(CFG_SCR_H, 15'h7fff);
    add_item(OP_CAST, 0, 0, 0);
    add_item(OP_CAST, 0, 0, 1023);
    add_item(OP_CAST, 0, 0, 1);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      idle_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 46 : 6;
      if (ph == 5) begin
        write_reg(CFG_POS_X, 15'h0000);
        write_reg(CFG_POS_Y, 15'h7fff);
        write_reg(CFG_DIR_X, 15'h0000);
        write_reg(CFG_DIR_Y, 15'h0001);
        write_reg(CFG_PLANE_X, 15'h0001);
        write_reg(CFG_PLANE_Y, 15'h0000);
        write_reg(CFG_SCR_W, 15'd1024);
        write_reg(CFG_SCR_H, 15'd1);
      end else begin
        for (int r = 0; r < 8; r++) begin
          if (r == CFG_SCR_W || r == CFG_SCR_H)
            write_reg(CFG_IDX_W'(r),
                      CFG_DATA_W'(($urandom_range(7) == 0) ? $urandom_range(32767)
                                                           : $urandom_range(1, 1024)));
          else if (r <= CFG_POS_Y)
            write_reg(CFG_IDX_W'(r), CFG_DATA_W'($urandom_range(2047, 30719)));
          else
            write_reg(CFG_IDX_W'(r), CFG_DATA_W'($urandom_range(32767)));
        end
      end
      random_items(80);
      // Hold off once until every outstanding column has come back.
      while (column_q.size() > 0 || pending_q.size() > 0) @(posedge clk);
      random_items(80);
      drain();
    end

    repeat (100) @(posedge clk);
    $display("Covered %0d checked columns and %0d tile writes over eight camera setups,",
             casts_seen, writes_sent);
    $display("including map edges, zero ray components and clamped screen sizes.");
    if (errors == 0 && column_q.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #200ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
